// ===== rtl/rfc_pkg.sv =====
// Shared types and constants for the response frame checker.
package rfc_pkg;

	localparam int POS_W = 17;

	localparam logic [23:0] HEADER_WORD  = 24'h55FCAA;
	localparam logic [7:0]  STATE_OK     = 8'h01;
	localparam logic [15:0] LEN_OVERHEAD = 16'd5;
	localparam logic [15:0] LEN_MIN      = 16'd6;

	localparam logic [7:0] CMD_RESET = 8'hA0;
	localparam logic [7:0] VER_RESET = 8'h01;

	// config register indexes
	localparam logic CFG_COMMAND = 1'b0;
	localparam logic CFG_VERSION = 1'b1;

	// input word kinds
	localparam logic ACT_BYTE    = 1'b0;
	localparam logic ACT_TIMEOUT = 1'b1;

	// result word kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_VERSION  = 3'd1,
		ST_COMMAND  = 3'd2,
		ST_HEADER   = 3'd3,
		ST_LENGTH   = 3'd4,
		ST_CHECKSUM = 3'd5,
		ST_STATE    = 3'd6,
		ST_TIMEOUT  = 3'd7
	} status_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		status_t     status;
		logic [15:0] payload_length;
		logic        last;
	} result_t;

endpackage

// ===== rtl/response_frame_checker_xor_core.sv =====
// Top level of the response frame checker with XOR checksum.
//
// Channel   Dir  Fields (low bit first)
// s_*       in   tdata: rx_byte[7:0]; tuser: action (1 = timeout)
// m_*       out  tdata: data_byte, byte_index, status, payload_length, pad;
//                tuser: kind (1 = status); tlast: last
// cfg_*     in   cfg_index 0 = expected_command, 1 = expected_version
//
// One word per cycle sustained while m_tready stays high. A word is held
// in the input register, is checked against the frame state in one pass,
// and its result (if any) lands in the output register.
// The input register keeps taking words while a result waits downstream;
// a stall on m_tready backs up into s_tready only once both registers
// are full. Reset clears frame state and loads the register defaults
// (command 0xA0, version 0x01).
module response_frame_checker_xor_core import rfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] action
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] data_byte, [23:8] byte_index,
	                               // [26:24] status, [42:27] payload_length
	output logic        m_tuser,   // [0] kind
	output logic        m_tlast,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0] exp_cmd_q;
	logic [7:0] exp_ver_q;

	// input register
	logic       valid_s1;
	logic       action_s1;
	logic [7:0] byte_s1;

	logic    can_take;
	logic    step;
	logic    res_valid;
	result_t res;
	result_t out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cmd_q <= CMD_RESET;
			exp_ver_q <= VER_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COMMAND: exp_cmd_q <= cfg_data;
				CFG_VERSION: exp_ver_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a held word moves on whenever the result register has room
	assign step     = valid_s1 && can_take;
	assign s_tready = !valid_s1 || can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tuser;
			byte_s1   <= s_tdata;
		end
	end

	rfc_frame u_frame (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.action           (action_s1),
		.rx_byte          (byte_s1),
		.expected_command (exp_cmd_q),
		.expected_version (exp_ver_q),
		.res_valid        (res_valid),
		.res              (res)
	);

	rfc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && res_valid),
		.din       (res),
		.can_take  (can_take),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.dout      (out)
	);

	assign m_tdata = {5'd0, out.payload_length, out.status, out.byte_index, out.data_byte};
	assign m_tuser = out.kind;
	assign m_tlast = out.last;

	// status results always close the frame, payload results never do
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == m_tuser))
		else $error("tlast disagrees with result kind");

	a_payload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_PAYLOAD) |-> (out.status == ST_OK))
		else $error("payload word carries a nonzero status");

	a_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		(step && action_s1 == ACT_TIMEOUT) |=>
			(m_tvalid && out.status == ST_TIMEOUT && m_tlast))
		else $error("timeout did not produce a timeout status");

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !(step && res_valid))
		else $error("result register overwritten while stalled");

endmodule

// ===== rtl/rfc_frame.sv =====
// Frame tracking state and per-byte checks.
module rfc_frame import rfc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          action,
	input  logic [7:0]    rx_byte,
	input  logic [7:0]    expected_command,
	input  logic [7:0]    expected_version,
	output logic          res_valid,
	output result_t       res
);

	logic [POS_W-1:0] pos_q, pos_d;
	logic [15:0]      len_q, len_d;
	logic [7:0]       xor_q, xor_d;
	logic [23:0]      hdr_q, hdr_d;
	logic [7:0]       ver_q, ver_d;
	logic [7:0]       cmd_q, cmd_d;
	logic [7:0]       code_q, code_d;

	logic [15:0]      plen;
	logic [POS_W-1:0] pos_end;
	logic [POS_W-1:0] idx_full;
	logic [7:0]       xor_new;

	assign plen     = len_q - LEN_OVERHEAD;
	assign pos_end  = {1'b0, len_q} + POS_W'(2);
	assign idx_full = pos_q - POS_W'(7);
	assign xor_new  = xor_q ^ rx_byte;

	always_comb begin
		pos_d  = pos_q;
		len_d  = len_q;
		xor_d  = xor_q;
		hdr_d  = hdr_q;
		ver_d  = ver_q;
		cmd_d  = cmd_q;
		code_d = code_q;
		res_valid = 1'b0;
		res = '{kind: KIND_PAYLOAD, data_byte: 8'd0, byte_index: 16'd0,
			status: ST_OK, payload_length: 16'd0, last: 1'b0};

		if (action == ACT_TIMEOUT) begin
			res_valid = 1'b1;
			res.kind  = KIND_STATUS;
			res.status = ST_TIMEOUT;
			res.last  = 1'b1;
			pos_d = '0;
			xor_d = 8'd0;
		end else if (pos_q < POS_W'(7)) begin
			if (pos_q < POS_W'(3))
				hdr_d = {hdr_q[15:0], rx_byte};
			else if (pos_q < POS_W'(5))
				len_d = {len_q[7:0], rx_byte};
			else if (pos_q == POS_W'(5))
				ver_d = rx_byte;
			else
				cmd_d = rx_byte;
			xor_d = xor_new;
			pos_d = pos_q + POS_W'(1);
		end else if (pos_q == POS_W'(7)) begin
			code_d = rx_byte;
			xor_d  = xor_new;
			res_valid = 1'b1;
			if (ver_q != expected_version || cmd_q != expected_command ||
			    hdr_q != HEADER_WORD || len_q < LEN_MIN) begin
				res.kind = KIND_STATUS;
				res.last = 1'b1;
				// first failing check wins
				if (ver_q != expected_version)
					res.status = ST_VERSION;
				else if (cmd_q != expected_command)
					res.status = ST_COMMAND;
				else if (hdr_q != HEADER_WORD)
					res.status = ST_HEADER;
				else
					res.status = ST_LENGTH;
				pos_d = '0;
				xor_d = 8'd0;
			end else begin
				res.data_byte = rx_byte;
				res.payload_length = plen;
				pos_d = POS_W'(8);
			end
		end else if (pos_q < pos_end) begin
			xor_d = xor_new;
			pos_d = pos_q + POS_W'(1);
			res_valid = 1'b1;
			res.data_byte  = rx_byte;
			res.byte_index = idx_full[15:0];
			res.payload_length = plen;
		end else begin
			// checksum byte closes the frame
			res_valid = 1'b1;
			res.kind  = KIND_STATUS;
			res.last  = 1'b1;
			res.payload_length = plen;
			if (xor_q != rx_byte)
				res.status = ST_CHECKSUM;
			else if (code_q != STATE_OK)
				res.status = ST_STATE;
			else
				res.status = ST_OK;
			pos_d = '0;
			xor_d = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			len_q  <= 16'd0;
			xor_q  <= 8'd0;
			hdr_q  <= 24'd0;
			ver_q  <= 8'd0;
			cmd_q  <= 8'd0;
			code_q <= 8'd0;
		end else if (step) begin
			pos_q  <= pos_d;
			len_q  <= len_d;
			xor_q  <= xor_d;
			hdr_q  <= hdr_d;
			ver_q  <= ver_d;
			cmd_q  <= cmd_d;
			code_q <= code_d;
		end
	end

endmodule

// ===== rtl/rfc_out_reg.sv =====
// Result register toward the downstream side.
module rfc_out_reg import rfc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t din,
	output logic    can_take,
	input  logic    out_ready,
	output logic    out_valid,
	output result_t dout
);

	logic    valid_q;
	result_t data_q;

	assign can_take  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign dout      = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

endmodule

// ===== tb/sv/tb_response_frame_checker_xor_core.sv =====
// Self-checking testbench for the response frame checker with XOR checksum.
`timescale 1ns / 1ps

module tb_response_frame_checker_xor_core;
	import rfc_pkg::*;

	// clock, reset and ports
	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;    // [7:0] rx_byte
	logic        s_tuser  = ACT_BYTE; // [0] action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;             // [7:0] data_byte, [23:8] byte_index,
	                                  // [26:24] status, [42:27] payload_length
	logic        m_tuser;             // [0] kind
	logic        m_tlast;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = CFG_COMMAND;
	logic [7:0]  cfg_data  = 8'h00;

	// shadow of the block: registers and frame state
	logic [7:0]  exp_cmd = CMD_RESET;
	logic [7:0]  exp_ver = VER_RESET;
	logic [16:0] f_pos   = '0;
	logic [15:0] f_len   = '0;
	logic [7:0]  f_xor   = '0;
	logic [23:0] f_hdr   = '0;
	logic [7:0]  f_ver   = '0;
	logic [7:0]  f_cmd   = '0;
	logic [7:0]  f_state = '0;

	// result words still owed by the block, oldest first
	result_t frame_results_q[$];

	int errors     = 0;
	int words_sent = 0;
	bit idle_en    = 1'b1; // random gaps on both sides
	int hold_req   = 0;    // receiver hold-off request, in cycles

	response_frame_checker_xor_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Frame state shadow
	// ------------------------------------------------------------------

	function automatic void post_result(logic kind, logic [7:0] data, logic [15:0] idx,
			status_t st, logic [15:0] plen, logic last);
		result_t r;
		r.kind           = kind;
		r.data_byte      = data;
		r.byte_index     = idx;
		r.status         = st;
		r.payload_length = plen;
		r.last           = last;
		frame_results_q.push_back(r);
	endfunction

	// Status word ends the frame; the next byte starts a fresh one.
	function automatic void close_frame(status_t st, logic [15:0] plen);
		f_pos   = '0;
		f_len   = '0;
		f_xor   = '0;
		f_hdr   = '0;
		f_ver   = '0;
		f_cmd   = '0;
		f_state = '0;
		post_result(KIND_STATUS, 8'h00, 16'h0000, st, plen, 1'b1);
	endfunction

	// One accepted input word through the deframer.
	function automatic void advance_frame(logic act, logic [7:0] b);
		logic [15:0] plen;
		if (act == ACT_TIMEOUT) begin
			close_frame(ST_TIMEOUT, 16'h0000);
		end else if (f_pos < 7) begin
			// sync bytes, length (big-endian), version, command
			if (f_pos < 3)
				f_hdr = {f_hdr[15:0], b};
			else if (f_pos < 5)
				f_len = {f_len[7:0], b};
			else if (f_pos == 5)
				f_ver = b;
			else
				f_cmd = b;
			f_xor = f_xor ^ b;
			f_pos = f_pos + 1;
		end else if (f_pos == 7) begin
			// state code byte: all header checks resolve here, in fixed order
			f_state = b;
			f_xor   = f_xor ^ b;
			if (f_ver != exp_ver)
				close_frame(ST_VERSION, 16'h0000);
			else if (f_cmd != exp_cmd)
				close_frame(ST_COMMAND, 16'h0000);
			else if (f_hdr != HEADER_WORD)
				close_frame(ST_HEADER, 16'h0000);
			else if (f_len < LEN_MIN)
				close_frame(ST_LENGTH, 16'h0000);
			else begin
				f_pos = 17'd8;
				post_result(KIND_PAYLOAD, b, 16'h0000, ST_OK, f_len - LEN_OVERHEAD, 1'b0);
			end
		end else begin
			plen = f_len - LEN_OVERHEAD;
			if (f_pos < 7 + plen) begin
				f_xor = f_xor ^ b;
				post_result(KIND_PAYLOAD, b, 16'(f_pos - 7), ST_OK, plen, 1'b0);
				f_pos = f_pos + 1;
			end else if (f_xor != b)
				close_frame(ST_CHECKSUM, plen);
			else if (f_state != STATE_OK)
				close_frame(ST_STATE, plen);
			else
				close_frame(ST_OK, plen);
		end
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (frame_results_q.size() == 0) begin
				$error("result word with nothing expected: tdata %h", m_tdata);
				errors++;
			end else begin
				want = frame_results_q.pop_front();
				cmp_field("kind", 16'(want.kind), 16'(m_tuser));
				cmp_field("data_byte", 16'(want.data_byte), 16'(m_tdata[7:0]));
				cmp_field("byte_index", want.byte_index, m_tdata[23:8]);
				cmp_field("status", 16'(want.status), 16'(m_tdata[26:24]));
				cmp_field("payload_length", want.payload_length, m_tdata[42:27]);
				cmp_field("last", 16'(want.last), 16'(m_tlast));
			end
		end
	end

	// Receiver: random stall before each word, plus the long hold-off on
	// request. tready is only dropped between words.
	initial begin
		int stall;
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_req > 0) begin
				n        = hold_req;
				hold_req = 0;
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			stall = idle_en ? $urandom_range(0, 13) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// ------------------------------------------------------------------
	// Driving helpers
	// ------------------------------------------------------------------

	// Offer one word after a random gap; hold it until accepted.
	task automatic send_word(input logic act, input logic [7:0] b);
		int gap;
		gap = idle_en ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		advance_frame(act, b);
	endtask

	// Wait until every owed result has come out, then let the pipe empty
	// (a word with no result may still be in flight).
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (frame_results_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Both registers, back to back; only called when idle.
	task automatic set_config(input logic [7:0] cmd, input logic [7:0] ver);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_COMMAND;
		cfg_data  <= cmd;
		@(posedge clk);
		cfg_index <= CFG_VERSION;
		cfg_data  <= ver;
		@(posedge clk);
		cfg_we    <= 1'b0;
		exp_cmd = cmd;
		exp_ver = ver;
	endtask

	// Build and send one frame. abort_at >= 0 replaces that byte with a
	// timeout. Stops early once the frame has been closed by the block.
	task automatic send_frame(input logic [23:0] hdr, input logic [15:0] len,
			input logic [7:0] ver, input logic [7:0] cmd, input logic [7:0] state,
			input bit bad_sum, input int abort_at);
		logic [7:0] fb[$];
		logic [7:0] x;
		int n_more;
		int i;
		fb.push_back(hdr[23:16]);
		fb.push_back(hdr[15:8]);
		fb.push_back(hdr[7:0]);
		fb.push_back(len[15:8]);
		fb.push_back(len[7:0]);
		fb.push_back(ver);
		fb.push_back(cmd);
		fb.push_back(state);
		n_more = (len >= LEN_MIN) ? int'(len) - 6 : 0;
		repeat (n_more) fb.push_back(8'($urandom));
		x = 8'h00;
		foreach (fb[k]) x = x ^ fb[k];
		if (bad_sum) x = x ^ 8'($urandom_range(1, 255));
		fb.push_back(x);
		for (i = 0; i < fb.size(); i++) begin
			if (i == abort_at) begin
				send_word(ACT_TIMEOUT, 8'($urandom));
				break;
			end
			send_word(ACT_BYTE, fb[i]);
			if (f_pos == 0) break;
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values of both registers accept a minimal and a short frame.
	task automatic test_defaults();
		send_frame(HEADER_WORD, LEN_MIN, VER_RESET, CMD_RESET, STATE_OK, 0, -1);
		send_frame(HEADER_WORD, 16'd9, VER_RESET, CMD_RESET, STATE_OK, 0, -1);
		wait_idle();
	endtask

	// Version beats command beats header beats length.
	task automatic test_check_order();
		send_frame(24'h55FCAB, 16'd2, 8'h02, 8'hA1, STATE_OK, 0, -1);
		send_frame(24'h54FCAA, 16'd0, VER_RESET, 8'h5A, STATE_OK, 0, -1);
		send_frame(24'h55FDAA, 16'd5, VER_RESET, CMD_RESET, STATE_OK, 0, -1);
		send_frame(HEADER_WORD, 16'd5, VER_RESET, CMD_RESET, STATE_OK, 0, -1);
		send_frame(HEADER_WORD, 16'd0, VER_RESET, CMD_RESET, 8'h00, 0, -1);
		wait_idle();
	endtask

	// Checksum failure wins over a bad state code.
	task automatic test_checksum_state();
		send_frame(HEADER_WORD, 16'd8, VER_RESET, CMD_RESET, 8'h02, 1, -1);
		send_frame(HEADER_WORD, 16'd7, VER_RESET, CMD_RESET, 8'h00, 0, -1);
		send_frame(HEADER_WORD, LEN_MIN, VER_RESET, CMD_RESET, 8'hFF, 0, -1);
		send_frame(HEADER_WORD, 16'd6, VER_RESET, CMD_RESET, STATE_OK, 1, -1);
		wait_idle();
	endtask

	// Timeout with no frame open, in the header, in payload, at checksum.
	task automatic test_timeout();
		send_word(ACT_TIMEOUT, 8'hFF);
		send_frame(HEADER_WORD, 16'd10, VER_RESET, CMD_RESET, STATE_OK, 0, 3);
		send_frame(HEADER_WORD, 16'd12, VER_RESET, CMD_RESET, STATE_OK, 0, 10);
		send_frame(HEADER_WORD, 16'd6, VER_RESET, CMD_RESET, STATE_OK, 0, 8);
		send_word(ACT_TIMEOUT, 8'h00);
		wait_idle();
	endtask

	// Register extremes; an old-setting frame must now fail.
	task automatic test_config_extremes();
		set_config(8'h00, 8'hFF);
		send_frame(HEADER_WORD, 16'd8, 8'hFF, 8'h00, STATE_OK, 0, -1);
		send_frame(HEADER_WORD, 16'd8, VER_RESET, CMD_RESET, STATE_OK, 0, -1);
		wait_idle();
		set_config(8'hFF, 8'h00);
		send_frame(HEADER_WORD, 16'd8, 8'h00, 8'hFF, STATE_OK, 0, -1);
		send_frame(HEADER_WORD, 16'd8, 8'h00, 8'hFE, STATE_OK, 0, -1);
		wait_idle();
		set_config(CMD_RESET, VER_RESET);
	endtask

	// Receiver holds off for a long time while the sender keeps offering
	// words back to back: both registers fill and s_tready drops.
	task automatic test_backpressure();
		idle_en  = 1'b0;
		hold_req = 300;
		send_frame(HEADER_WORD, 16'd20, exp_ver, exp_cmd, STATE_OK, 0, -1);
		send_frame(HEADER_WORD, 16'd14, exp_ver, exp_cmd, 8'h03, 0, -1);
		send_frame(HEADER_WORD, 16'd11, exp_ver, exp_cmd, STATE_OK, 1, -1);
		wait_idle();
		idle_en = 1'b1;
	endtask

	// Largest length: payload length at its top in every payload word.
	// The frame is abandoned by a timeout a few payload bytes in.
	task automatic test_long_frame();
		idle_en = 1'b0;
		send_frame(HEADER_WORD, 16'hFFFF, exp_ver, exp_cmd, STATE_OK, 0, 12);
		wait_idle();
		idle_en = 1'b1;
	endtask

	// Mostly well-formed frames with random content, some broken ones and
	// some noise; config changes between phases.
	task automatic test_random();
		int start;
		int phase_end;
		int pick;
		int n;
		logic [23:0] hdr;
		logic [15:0] len;
		logic [7:0]  ver;
		logic [7:0]  cmd;
		logic [7:0]  st;
		bit          bad;
		int          abort_at;
		start = words_sent;
		while (words_sent - start < 600) begin
			wait_idle();
			pick = $urandom_range(0, 3);
			case (pick)
				0: set_config(8'h00, 8'h00);
				1: set_config(8'hFF, 8'hFF);
				default: set_config(8'($urandom), 8'($urandom));
			endcase
			idle_en   = ($urandom_range(0, 3) != 0);
			phase_end = words_sent + 120;
			while (words_sent < phase_end) begin
				hdr      = HEADER_WORD;
				ver      = exp_ver;
				cmd      = exp_cmd;
				len      = 16'($urandom_range(6, 24));
				st       = ($urandom_range(0, 3) == 0) ? 8'($urandom) : STATE_OK;
				bad      = ($urandom_range(0, 7) == 0);
				abort_at = -1;
				pick     = $urandom_range(0, 99);
				if (pick < 7)
					ver = ver ^ 8'($urandom_range(1, 255));
				else if (pick < 14)
					cmd = cmd ^ 8'($urandom_range(1, 255));
				else if (pick < 20)
					hdr = hdr ^ (24'h1 << $urandom_range(0, 23));
				else if (pick < 26)
					len = 16'($urandom_range(0, 5));
				else if (pick < 32)
					abort_at = $urandom_range(0, int'(len) + 2);
				else if (pick < 34)
					len = 16'($urandom_range(100, 400));
				if (pick >= 94) begin
					// noise words, usually followed by a timeout to resync
					n = $urandom_range(1, 5);
					repeat (n)
						send_word(($urandom_range(0, 4) == 0) ? ACT_TIMEOUT : ACT_BYTE,
							8'($urandom));
					if ($urandom_range(0, 3) != 0)
						send_word(ACT_TIMEOUT, 8'($urandom));
				end else
					send_frame(hdr, len, ver, cmd, st, bad, abort_at);
			end
		end
		wait_idle();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_check_order();
		test_checksum_state();
		test_timeout();
		test_config_extremes();
		test_backpressure();
		test_long_frame();
		test_random();
		// wait_idle already drained and waited out the pipeline
		if (errors == 0)
			$display("[response_frame_checker_xor_core] OK");
		else
			$display("[response_frame_checker_xor_core] ERROR");
		$finish;
	end

	// Watchdog: well above the slowest correct run.
	initial begin
		#4000000;
		$display("[response_frame_checker_xor_core] ERROR");
		$finish;
	end

endmodule
